// ===== hdl/string_to_integer_parser_macros.svh =====
// Assertion macros shared by the string-to-integer parser RTL.
`ifndef STRING_TO_INTEGER_PARSER_MACROS_SVH
`define STRING_TO_INTEGER_PARSER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define STIP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define STIP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/stip_pkg.sv =====
// Shared types, constants and helpers for the string-to-integer parser.
package stip_pkg;

  localparam int CharW      = 8;
  localparam int BaseW      = 6;
  localparam int ValueW     = 64;
  localparam int ConsumedW  = 13;
  localparam int DigitW     = 7;
  localparam int MaxCharsDefault = 4096;

  // Parse phases
  localparam logic [2:0] PH_SPACE  = 3'd0;
  localparam logic [2:0] PH_PREFIX = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_DIGITS = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  localparam logic [BaseW-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BaseW-1:0] BASE_OCT   = 6'd8;
  localparam logic [BaseW-1:0] BASE_DEC   = 6'd10;
  localparam logic [BaseW-1:0] BASE_HEX   = 6'd16;
  localparam logic [BaseW-1:0] BASE_RESET = BASE_DEC;

  localparam logic [CharW-1:0] CH_NUL   = 8'h00;
  localparam logic [CharW-1:0] CH_TAB   = 8'h09;
  localparam logic [CharW-1:0] CH_LF    = 8'h0A;
  localparam logic [CharW-1:0] CH_SPACE = 8'h20;
  localparam logic [CharW-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CharW-1:0] CH_MINUS = 8'h2D;
  localparam logic [CharW-1:0] CH_0     = 8'h30;
  localparam logic [CharW-1:0] CH_9     = 8'h39;
  localparam logic [CharW-1:0] CH_UA    = 8'h41;
  localparam logic [CharW-1:0] CH_UX    = 8'h58;
  localparam logic [CharW-1:0] CH_UZ    = 8'h5A;
  localparam logic [CharW-1:0] CH_LA    = 8'h61;
  localparam logic [CharW-1:0] CH_LX    = 8'h78;
  localparam logic [CharW-1:0] CH_LZ    = 8'h7A;

  localparam logic [DigitW-1:0] DIGIT_NONE = 7'd64;
  localparam logic [CharW-1:0]  LETTER_OFS = 8'd10;

  typedef struct packed {
    logic [2:0]       phase;
    logic [BaseW-1:0] base;
    logic             neg;
    logic             wrapped;
  } stip_ctl_t;

  // Digit value of a character, or a value no 6-bit base accepts.
  function automatic logic [DigitW-1:0] digit_of(input logic [CharW-1:0] c);
    logic [CharW-1:0] v;
    v = '0;
    if (c >= CH_0 && c <= CH_9) begin
      v = c - CH_0;
      return v[DigitW-1:0];
    end
    if (c >= CH_LA && c <= CH_LZ) begin
      v = c - CH_LA + LETTER_OFS;
      return v[DigitW-1:0];
    end
    if (c >= CH_UA && c <= CH_UZ) begin
      v = c - CH_UA + LETTER_OFS;
      return v[DigitW-1:0];
    end
    return DIGIT_NONE;
  endfunction

endpackage

// ===== hdl/stip_step.sv =====
// Next-state logic for one character of the integer parser.
module stip_step #(
  parameter int MAX_CHARS = stip_pkg::MaxCharsDefault,
  localparam int CntW = $clog2(MAX_CHARS + 1)
) (
  input  stip_pkg::stip_ctl_t              ctl_cur,
  input  logic [stip_pkg::ValueW-1:0]      mag_cur,
  input  logic [CntW-1:0]                  cnt_cur,
  input  logic [stip_pkg::CharW-1:0]       char_code,
  output stip_pkg::stip_ctl_t              ctl_nxt,
  output logic [stip_pkg::ValueW-1:0]      mag_nxt,
  output logic [CntW-1:0]                  cnt_nxt
);
  import stip_pkg::*;

  logic                   inc;
  logic                   take_dig;
  logic [BaseW-1:0]       dig_base;
  logic [DigitW-1:0]      dig_val;
  logic                   dig_stop;
  logic [ValueW+BaseW-1:0] acc;
  logic                   is_x;

  // Base used for a digit: auto falls back to octal after a leading zero, else decimal.
  assign dig_base = (ctl_cur.base != BASE_AUTO) ? ctl_cur.base :
                    (ctl_cur.phase == PH_ZERO) ? BASE_OCT : BASE_DEC;
  assign is_x     = (char_code == CH_LX) || (char_code == CH_UX);
  assign dig_val  = digit_of(char_code);
  assign dig_stop = (char_code == CH_NUL) || (dig_val >= {1'b0, dig_base});
  assign acc      = ({{BaseW{1'b0}}, mag_cur} * {{ValueW{1'b0}}, dig_base})
                    + {{(ValueW+BaseW-DigitW){1'b0}}, dig_val};

  always_comb begin
    ctl_nxt  = ctl_cur;
    mag_nxt  = mag_cur;
    inc      = 1'b0;
    take_dig = 1'b0;

    unique case (ctl_cur.phase) inside
      PH_SPACE, PH_PREFIX: begin
        if (ctl_cur.phase == PH_SPACE &&
            (char_code == CH_SPACE || char_code == CH_TAB || char_code == CH_LF)) begin
          inc = 1'b1;
        end else if (ctl_cur.phase == PH_SPACE && char_code == CH_MINUS) begin
          ctl_nxt.neg   = 1'b1;
          ctl_nxt.phase = PH_PREFIX;
          inc           = 1'b1;
        end else if (ctl_cur.phase == PH_SPACE && char_code == CH_PLUS) begin
          ctl_nxt.phase = PH_PREFIX;
          inc           = 1'b1;
        end else if ((ctl_cur.base == BASE_AUTO || ctl_cur.base == BASE_HEX) &&
                     char_code == CH_0) begin
          ctl_nxt.phase = PH_ZERO;
          inc           = 1'b1;
        end else begin
          // no prefix: auto base falls back to decimal
          ctl_nxt.base  = dig_base;
          ctl_nxt.phase = PH_DIGITS;
          take_dig      = 1'b1;
        end
      end
      PH_ZERO: begin
        if (is_x) begin
          ctl_nxt.base  = BASE_HEX;
          ctl_nxt.phase = PH_DIGITS;
          inc           = 1'b1;
        end else begin
          ctl_nxt.base  = dig_base;
          ctl_nxt.phase = PH_DIGITS;
          take_dig      = 1'b1;
        end
      end
      PH_DIGITS: begin
        take_dig = 1'b1;
      end
      default: begin
      end
    endcase

    if (take_dig) begin
      if (dig_stop) begin
        ctl_nxt.phase = PH_DONE;
      end else begin
        mag_nxt         = acc[ValueW-1:0];
        ctl_nxt.wrapped = ctl_cur.wrapped | (|acc[ValueW+BaseW-1:ValueW]);
        inc             = 1'b1;
      end
    end
  end

  // Saturate the consumed count.
  assign cnt_nxt = (inc && cnt_cur < CntW'(MAX_CHARS)) ? cnt_cur + 1'b1 : cnt_cur;

endmodule

// ===== hdl/string_to_integer_parser.sv =====
// Top level of the streaming string-to-integer parser.
// Usage: feed one character per request on the in_ channel (in_tdata = character
// code, in_tuser = start of a new string). Each request yields exactly one result
// request on the out_ channel describing the parse so far: signed value, count of
// consumed characters, a done flag and a sticky overflow flag.
// Parsing follows strtol: skip space/tab/newline, optional sign, 0x/0X prefix in
// base 0 or 16, leading zero selects octal in base 0, then digits until one is not
// below the base or a NUL arrives. Consumed saturates at MAX_CHARS.
// Timing: two register stages (input register, result register); the character is
// captured in the input register, processed into the result register, and out_tvalid
// then rises. One character per cycle is sustained while the receiver does not stall;
// the combinational multiply-by-base and add in the step logic sets the clock period.
// The base register (cfg_wr_en/cfg_wr_data) takes effect at the next string start.
// Reset clears the parse state, loads base 10 and empties both stages.
// When the receiver stalls, the result register holds, the input register fills,
// and in_tready drops until the result drains.
module string_to_integer_parser #(
  parameter int MAX_CHARS = stip_pkg::MaxCharsDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration: number_base
  input  logic                          cfg_wr_en,
  input  logic [stip_pkg::BaseW-1:0]    cfg_wr_data,
  // input channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] char_code
  input  logic [0:0]                    in_tuser,   // [0] start_new
  // result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [79:0]                   out_tdata,  // [63:0] value, [76:64] consumed
  output logic [1:0]                    out_tuser   // [0] done_res, [1] overflow
);
  import stip_pkg::*;

  `include "string_to_integer_parser_macros.svh"

  localparam int CntW = $clog2(MAX_CHARS + 1);

  // configuration
  logic [BaseW-1:0]  cfg_base_r;

  // input register
  logic              s1_valid_r;
  logic [CharW-1:0]  s1_char_r;
  logic              s1_start_r;

  // parse state
  stip_ctl_t         ctl_r, ctl_eff, ctl_nxt;
  logic [ValueW-1:0] mag_r, mag_eff, mag_nxt;
  logic [CntW-1:0]   cnt_r, cnt_eff, cnt_nxt;

  // result register
  logic                  out_valid_r;
  logic [ValueW-1:0]     out_mag_r;
  logic                  out_neg_r;
  logic [ConsumedW-1:0]  out_cnt_r;
  logic                  out_done_r;
  logic                  out_ovf_r;

  logic                        advance;
  logic [CntW+ConsumedW-1:0]   cnt_ext;
  logic [ValueW-1:0]           out_value;

  // Advance when the input register holds a request and the result slot frees.
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  // Apply the string-start clear before the step logic.
  always_comb begin
    if (s1_start_r) begin
      ctl_eff.phase   = PH_SPACE;
      ctl_eff.base    = cfg_base_r;
      ctl_eff.neg     = 1'b0;
      ctl_eff.wrapped = 1'b0;
      mag_eff         = '0;
      cnt_eff         = '0;
    end else begin
      ctl_eff = ctl_r;
      mag_eff = mag_r;
      cnt_eff = cnt_r;
    end
  end

  stip_step #(
    .MAX_CHARS (MAX_CHARS)
  ) u_step (
    .ctl_cur   (ctl_eff),
    .mag_cur   (mag_eff),
    .cnt_cur   (cnt_eff),
    .char_code (s1_char_r),
    .ctl_nxt   (ctl_nxt),
    .mag_nxt   (mag_nxt),
    .cnt_nxt   (cnt_nxt)
  );

  assign cnt_ext = {{ConsumedW{1'b0}}, cnt_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_base_r <= BASE_RESET;
    end else if (cfg_wr_en) begin
      cfg_base_r <= cfg_wr_data;
    end
  end

  // Input register: load on accept, drop once advanced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_char_r  <= in_tdata;
      s1_start_r <= in_tuser[0];
    end
  end

  // Parse state advances with each processed character.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.phase   <= PH_SPACE;
      ctl_r.base    <= BASE_RESET;
      ctl_r.neg     <= 1'b0;
      ctl_r.wrapped <= 1'b0;
      mag_r         <= '0;
      cnt_r         <= '0;
    end else if (advance) begin
      ctl_r <= ctl_nxt;
      mag_r <= mag_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Result register: hold while the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_mag_r  <= mag_nxt;
      out_neg_r  <= ctl_nxt.neg;
      out_cnt_r  <= cnt_ext[ConsumedW-1:0];
      out_done_r <= (ctl_nxt.phase == PH_DONE);
      out_ovf_r  <= ctl_nxt.wrapped;
    end
  end

  // Two's-complement negate after the register keeps the step path short.
  assign out_value  = out_neg_r ? (ValueW'(0) - out_mag_r) : out_mag_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_cnt_r, out_value};
  assign out_tuser  = {out_ovf_r, out_done_r};

  // Once stopped, a string stays stopped until the next start.
  `STIP_ASSERT_NEXT(a_done_sticky, advance && !s1_start_r && ctl_r.phase == PH_DONE, ctl_r.phase == PH_DONE, "parse resumed after done")
  // Overflow is sticky within a string.
  `STIP_ASSERT_NEXT(a_wrap_sticky, advance && !s1_start_r && ctl_r.wrapped, ctl_r.wrapped, "overflow flag cleared mid-string")
  // Consumed count never passes its ceiling.
  `STIP_ASSERT_NOW(a_cnt_limit, 1'b1, cnt_r <= CntW'(MAX_CHARS), "consumed count above limit")
  // A processed character always leaves a pending result.
  `STIP_ASSERT_NEXT(a_result_loaded, advance, out_valid_r, "result lost after advance")

endmodule
